// File: hw/rtl/length_prefixed_adler32_deframer_core_macros.svh
// ---------------------------------------------------------------------------
// assertion macros shared by the deframer rtl
// ---------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_ADLER32_DEFRAMER_CORE_MACROS_SVH
`define LENGTH_PREFIXED_ADLER32_DEFRAMER_CORE_MACROS_SVH

// plain check, sampled on clk, off during reset
`define LPAD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication check, sampled on clk, off during reset
`define LPAD_ASSERT_IMP(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

// next-cycle check, sampled on clk, off during reset
`define LPAD_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

// File: hw/rtl/lpad_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lpad_pkg
// shared types and constants of the length-prefixed adler-32 deframer
// ---------------------------------------------------------------------------
package lpad_pkg;

  // frame length width and largest representable length
  localparam int LEN_W = 16;
  localparam logic [31:0] LEN_MAX = 32'((64'd1 << LEN_W) - 64'd1);

  // adler-32 modulus
  localparam logic [16:0] ADLER_MOD = 17'd65521;

  // queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // configuration register indexes
  localparam logic [7:0] CFG_MIN_NAME_LEN  = 8'd0;
  localparam logic [7:0] CFG_MAX_FRAME_LEN = 8'd1;

  // region tags
  localparam logic [1:0] RGN_NAME_LEN = 2'd0;
  localparam logic [1:0] RGN_NAME     = 2'd1;
  localparam logic [1:0] RGN_BODY     = 2'd2;
  localparam logic [1:0] RGN_TRAILER  = 2'd3;

  // frame status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_LEN  = 2'd1;
  localparam logic [1:0] ST_CHECKSUM = 2'd2;
  localparam logic [1:0] ST_BAD_NAME = 2'd3;

  // classified item handed from front to back
  typedef struct packed {
    logic [7:0] data;
    logic [1:0] region;
    logic       sum_en;    // byte goes into the running checksum
    logic       last;      // last payload byte of the frame
    logic       err;       // invalid frame length result
    logic       name_bad;  // name length out of range, valid with last
  } item_t;

endpackage

// File: hw/rtl/lpad_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lpad_queue
// small register fifo that decouples the parser front from the back end
// ---------------------------------------------------------------------------
`include "length_prefixed_adler32_deframer_core_macros.svh"

module lpad_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lpad_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output lpad_pkg::item_t pop_item
);

  lpad_pkg::item_t                   entries [lpad_pkg::QDEPTH];
  logic [lpad_pkg::QPTR_W-1:0]       wr_ptr;
  logic [lpad_pkg::QPTR_W-1:0]       rd_ptr;
  logic [lpad_pkg::QCNT_W-1:0]       count;

  assign full      = (count == lpad_pkg::QCNT_W'(lpad_pkg::QDEPTH));
  assign not_empty = (count != '0);
  assign pop_item  = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == lpad_pkg::QPTR_W'(lpad_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == lpad_pkg::QPTR_W'(lpad_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `LPAD_ASSERT(a_q_count_range, count <= lpad_pkg::QCNT_W'(lpad_pkg::QDEPTH), "queue count overflow")
  `LPAD_ASSERT_IMP(a_q_pop_nonempty, pop, not_empty, "pop from empty queue")

endmodule

// File: hw/rtl/lpad_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lpad_front
// frame parser: gathers the length field, checks it and tags payload bytes
// ---------------------------------------------------------------------------
`include "length_prefixed_adler32_deframer_core_macros.svh"

module lpad_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [7:0]      in_byte,
  input  logic [7:0]      min_name_len,
  input  logic [15:0]     max_frame_len,
  output logic            push,
  output lpad_pkg::item_t push_item
);

  localparam logic PH_LENGTH  = 1'b0;
  localparam logic PH_PAYLOAD = 1'b1;
  localparam int   LW         = lpad_pkg::LEN_W;

  logic          phase;
  logic [31:0]   length_shift;
  logic [LW-1:0] frame_length;
  logic [LW-1:0] byte_count;
  logic [31:0]   name_length;
  logic [LW-1:0] name_ext;
  logic          name_bad;
  logic          error_lock;

  logic [31:0]   len_new;
  logic [31:0]   len_limit;
  logic [31:0]   len_min;
  logic          len_bad;
  logic [LW-1:0] span;
  logic [LW-1:0] trail_start;
  logic [LW-1:0] last_idx;
  logic [31:0]   nl_new;
  logic [31:0]   span_ext;
  logic          nl_bad;
  logic          is_last;
  logic [1:0]    rgn;

  // length field check
  always_comb begin
    len_new   = {length_shift[23:0], in_byte};
    len_min   = {24'd0, min_name_len} + 32'd8;
    len_limit = ({16'd0, max_frame_len} > lpad_pkg::LEN_MAX) ? lpad_pkg::LEN_MAX
                                                              : {16'd0, max_frame_len};
    len_bad   = (len_new < len_min) || (len_new > len_limit);
  end

  // payload position classification
  always_comb begin
    span        = frame_length - LW'(8);
    trail_start = frame_length - LW'(4);
    last_idx    = frame_length - LW'(1);
    nl_new      = {name_length[23:0], in_byte};
    span_ext    = 32'(span);
    nl_bad      = (nl_new < {24'd0, min_name_len}) || (nl_new > span_ext);
    is_last     = (byte_count == last_idx);
    if (byte_count < LW'(4)) begin
      rgn = lpad_pkg::RGN_NAME_LEN;
    end else if (byte_count >= trail_start) begin
      rgn = lpad_pkg::RGN_TRAILER;
    end else if ((byte_count - LW'(4)) < name_ext) begin
      rgn = lpad_pkg::RGN_NAME;
    end else begin
      rgn = lpad_pkg::RGN_BODY;
    end
  end

  // item toward the queue
  always_comb begin
    push      = 1'b0;
    push_item = '0;
    if (accept && !error_lock) begin
      if (phase == PH_LENGTH) begin
        if (byte_count[1:0] == 2'd3 && len_bad) begin
          push           = 1'b1;
          push_item.err  = 1'b1;
          push_item.last = 1'b1;
        end
      end else begin
        push               = 1'b1;
        push_item.data     = in_byte;
        push_item.region   = rgn;
        push_item.sum_en   = (byte_count < trail_start);
        push_item.last     = is_last;
        push_item.name_bad = name_bad;
      end
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_LENGTH;
      length_shift <= '0;
      frame_length <= '0;
      byte_count   <= '0;
      name_length  <= '0;
      name_ext     <= '0;
      name_bad     <= 1'b0;
      error_lock   <= 1'b0;
    end else if (accept && !error_lock) begin
      if (phase == PH_LENGTH) begin
        length_shift <= len_new;
        if (byte_count[1:0] != 2'd3) begin
          byte_count <= byte_count + 1'b1;
        end else if (len_bad) begin
          error_lock <= 1'b1;
        end else begin
          frame_length <= len_new[LW-1:0];
          byte_count   <= '0;
          phase        <= PH_PAYLOAD;
        end
      end else begin
        if (byte_count < LW'(4)) begin
          name_length <= nl_new;
        end
        if (byte_count == LW'(3)) begin
          name_bad <= nl_bad;
          name_ext <= (nl_new > span_ext) ? span : nl_new[LW-1:0];
        end
        if (is_last) begin
          phase        <= PH_LENGTH;
          length_shift <= '0;
          frame_length <= '0;
          byte_count   <= '0;
          name_length  <= '0;
          name_ext     <= '0;
          name_bad     <= 1'b0;
        end else begin
          byte_count <= byte_count + 1'b1;
        end
      end
    end
  end

  `LPAD_ASSERT_IMP(a_fr_lock_silent, error_lock, !push, "item pushed while locked")
  `LPAD_ASSERT_NEXT(a_fr_err_locks, push && push_item.err, error_lock, "length error did not lock")

endmodule

// File: hw/rtl/lpad_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lpad_back
// adler-32 accumulation, status resolution and output register
// ---------------------------------------------------------------------------
`include "length_prefixed_adler32_deframer_core_macros.svh"

module lpad_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            not_empty,
  input  lpad_pkg::item_t item,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_byte,
  output logic [1:0]      region,
  output logic            frame_end,
  output logic [1:0]      status
);

  logic [15:0] adler_low;
  logic [15:0] adler_high;
  logic [31:0] received_sum;

  logic [16:0] low_sum;
  logic [15:0] low_next;
  logic [16:0] high_sum;
  logic [15:0] high_next;
  logic [31:0] rs_next;
  logic [1:0]  st;

  // take an item when the output register is free or being drained
  assign pop = not_empty && (!out_valid || out_ready);

  // running checksum and trailer status
  always_comb begin
    low_sum   = {1'b0, adler_low} + {9'd0, item.data};
    low_next  = (low_sum >= lpad_pkg::ADLER_MOD) ? 16'(low_sum - lpad_pkg::ADLER_MOD)
                                                 : low_sum[15:0];
    high_sum  = {1'b0, adler_high} + {1'b0, low_next};
    high_next = (high_sum >= lpad_pkg::ADLER_MOD) ? 16'(high_sum - lpad_pkg::ADLER_MOD)
                                                  : high_sum[15:0];
    rs_next   = {received_sum[23:0], item.data};
    if ({adler_high, adler_low} != rs_next) begin
      st = lpad_pkg::ST_CHECKSUM;
    end else if (item.name_bad) begin
      st = lpad_pkg::ST_BAD_NAME;
    end else begin
      st = lpad_pkg::ST_OK;
    end
  end

  // checksum state
  always_ff @(posedge clk) begin
    if (rst) begin
      adler_low    <= 16'd1;
      adler_high   <= '0;
      received_sum <= '0;
    end else if (pop && !item.err) begin
      if (item.last) begin
        adler_low    <= 16'd1;
        adler_high   <= '0;
        received_sum <= '0;
      end else if (item.sum_en) begin
        adler_low  <= low_next;
        adler_high <= high_next;
      end else begin
        received_sum <= rs_next;
      end
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (pop) begin
      if (item.err) begin
        out_byte  <= '0;
        region    <= lpad_pkg::RGN_NAME_LEN;
        frame_end <= 1'b1;
        status    <= lpad_pkg::ST_BAD_LEN;
      end else begin
        out_byte  <= item.data;
        region    <= item.region;
        frame_end <= item.last;
        status    <= item.last ? st : lpad_pkg::ST_OK;
      end
    end
  end

  `LPAD_ASSERT_NEXT(a_bk_frame_restart, pop && item.last && !item.err,
    adler_low == 16'd1 && adler_high == 16'd0, "checksum not restarted after frame")

endmodule

// File: hw/rtl/length_prefixed_adler32_deframer_core.sv
`timescale 1ns / 1ps
// path: an accepted payload byte or length error goes through the queue to the output register
// throughput: one byte per cycle unless stalled; the parser and checksum unit each take 1/cycle
// a 2-entry queue between front and back plus the output register absorb output stalls
// reset: synchronous, clears the parser, the error lock, the queue and the checksum state,
// and loads min_name_len 2 and max_frame_len 65535; no clearing pass
// ---------------------------------------------------------------------------
// length_prefixed_adler32_deframer_core
// deframes length-prefixed frames and checks their adler-32 trailer
// ---------------------------------------------------------------------------

module length_prefixed_adler32_deframer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic [1:0]  region,
  output logic        frame_end,
  output logic [1:0]  status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [7:0]      min_name_len;
  logic [15:0]     max_frame_len;
  logic            q_push;
  logic            q_full;
  logic            q_pop;
  logic            q_not_empty;
  lpad_pkg::item_t q_in;
  lpad_pkg::item_t q_out;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_name_len  <= 8'd2;
      max_frame_len <= 16'hFFFF;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == lpad_pkg::CFG_MIN_NAME_LEN) begin
        min_name_len <= cfg_data[7:0];
      end else if (cfg_index == lpad_pkg::CFG_MAX_FRAME_LEN) begin
        max_frame_len <= cfg_data;
      end
    end
  end

  // parser front
  lpad_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (in_valid && in_ready),
    .in_byte       (in_byte),
    .min_name_len  (min_name_len),
    .max_frame_len (max_frame_len),
    .push          (q_push),
    .push_item     (q_in)
  );

  // decoupling queue
  lpad_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_item  (q_out)
  );

  // checksum back end
  lpad_back u_back (
    .clk       (clk),
    .rst       (rst),
    .not_empty (q_not_empty),
    .item      (q_out),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .region    (region),
    .frame_end (frame_end),
    .status    (status)
  );

endmodule
